/* design/sspd_pkg.sv */
// ----------------------------------------------------------------------------
// sspd_pkg
// Types and constants shared by the scale-space peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sspd_pkg;

   localparam int RESPONSE_BITS          = 32;
   localparam int MAX_ROW_LENGTH_DEFAULT = 1024;
   localparam int MAX_ROW_COUNT          = 1024;
   localparam int COORD_BITS             = 10;
   localparam int ROW_BITS               = 10;
   localparam int CFG_LEN_BITS           = 11;
   localparam int BORDER_BITS            = 8;
   localparam int CSR_INDEX_BITS         = 2;
   localparam int LAYERS                 = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD    = 2'd0,
      CSR_ROW_LENGTH   = 2'd1,
      CSR_ROW_COUNT    = 2'd2,
      CSR_BORDER_WIDTH = 2'd3
   } csr_index_type;

   typedef logic [RESPONSE_BITS-1:0] resp_type;
   // one window column of one layer: oldest row at [0], newest at [2]
   typedef resp_type [2:0] col_type;
   // one window column of all layers: lower [0], centre [1], upper [2]
   typedef col_type [LAYERS-1:0] stack_type;

   typedef struct packed {
      logic signed [RESPONSE_BITS-1:0] lower_response;
      logic signed [RESPONSE_BITS-1:0] centre_response;
      logic signed [RESPONSE_BITS-1:0] upper_response;
      logic                            frame_start;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]           peak_x;
      logic [COORD_BITS-1:0]           peak_y;
      logic signed [RESPONSE_BITS-1:0] peak_strength;
   } rsp_type;

   typedef struct packed {
      logic     load;
      resp_type threshold;
   } nms_ctrl_type;

endpackage

`default_nettype wire

/* design/sspd_ram.sv */
// ----------------------------------------------------------------------------
// sspd_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/sspd_nms.sv */
// ----------------------------------------------------------------------------
// sspd_nms
// 3x3x3 neighborhood window and the non-maximum test on its centre.
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_nms (
   input  wire logic                   clock,
   input  wire sspd_pkg::nms_ctrl_type ctrl,
   input  wire sspd_pkg::stack_type    col_in,
   output logic                        is_peak,
   output logic [sspd_pkg::RESPONSE_BITS-1:0] centre_value
);

   import sspd_pkg::*;

   // win_ff[layer][column], column 2 is newest
   col_type win_ff [LAYERS][3];
   resp_type val;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         for (int l = 0; l < LAYERS; l++) begin
            win_ff[l][0] <= win_ff[l][1];
            win_ff[l][1] <= win_ff[l][2];
            win_ff[l][2] <= col_in[l];
         end
      end
   end

   assign val = win_ff[1][1][1];

   // centre vs itself never fails the strict compare, so all 27 are checked
   always_comb begin
      logic ok;
      ok = $signed(val) >= $signed(ctrl.threshold);
      for (int l = 0; l < LAYERS; l++) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               if ($signed(win_ff[l][c][r]) > $signed(val)) begin
                  ok = 1'b0;
               end
            end
         end
      end
      is_peak = ok;
   end

   assign centre_value = val;

endmodule

`default_nettype wire

/* design/scale_space_peak_detector.sv */
// ----------------------------------------------------------------------------
// scale_space_peak_detector
// 3x3x3 non-maximum suppression over three streamed response layers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | sspd_pkg::req_type
//  rsp_    | out       | rsp_valid/rsp_stall | sspd_pkg::rsp_type
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
//  One request per cycle while req_stall is low; a peak passes through the
//  line-buffer read, the window shift and the result register before it
//  appears on rsp_.
//  Reset clears raster counters and pipeline valids, sets the configuration
//  registers to defaults, and leaves the line buffers stale until rewritten.
//  A stalled result stalls req_ only once both internal stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_space_peak_detector #(
   parameter int MAX_ROW_LENGTH = sspd_pkg::MAX_ROW_LENGTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sspd_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sspd_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sspd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [sspd_pkg::RESPONSE_BITS-1:0]  csr_data
);

   import sspd_pkg::*;

   localparam int CW = $clog2(MAX_ROW_LENGTH);
   localparam int LW = (CW + 1 > CFG_LEN_BITS) ? CW + 1 : CFG_LEN_BITS;

   // configuration
   resp_type                threshold_ff;
   logic [CFG_LEN_BITS-1:0] row_length_ff;
   logic [CFG_LEN_BITS-1:0] row_count_ff;
   logic [BORDER_BITS-1:0]  border_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         row_length_ff   <= CFG_LEN_BITS'(1024);
         row_count_ff    <= CFG_LEN_BITS'(1024);
         border_width_ff <= BORDER_BITS'(1);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD:    threshold_ff    <= csr_data;
            CSR_ROW_LENGTH:   row_length_ff   <= csr_data[CFG_LEN_BITS-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_data[CFG_LEN_BITS-1:0];
            CSR_BORDER_WIDTH: border_width_ff <= csr_data[BORDER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size
   logic [LW-1:0]           rl_ext;
   logic [LW-1:0]           w_eff;
   logic [CFG_LEN_BITS-1:0] h_eff;

   assign rl_ext = LW'(row_length_ff);

   always_comb begin
      if (rl_ext < LW'(3)) begin
         w_eff = LW'(3);
      end else if (rl_ext > LW'(MAX_ROW_LENGTH)) begin
         w_eff = LW'(MAX_ROW_LENGTH);
      end else begin
         w_eff = rl_ext;
      end
      if (row_count_ff < CFG_LEN_BITS'(3)) begin
         h_eff = CFG_LEN_BITS'(3);
      end else if (row_count_ff > CFG_LEN_BITS'(MAX_ROW_COUNT)) begin
         h_eff = CFG_LEN_BITS'(MAX_ROW_COUNT);
      end else begin
         h_eff = row_count_ff;
      end
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s2_cand_ff;
   logic is_peak;
   logic out_free, s2_result, s2_free, s1_free, s1_move, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_result = s2_valid_ff && s2_cand_ff && is_peak;
   assign s2_free   = !s2_result || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // raster position
   logic [CW-1:0]       column_count_ff, column_count_in;
   logic [ROW_BITS-1:0] row_index_ff, row_index_in;
   logic [CW-1:0]       x;
   logic [ROW_BITS-1:0] y;
   logic [LW-1:0]       x_inc;
   logic [ROW_BITS:0]   y_inc;

   assign x     = req_data.frame_start ? '0 : column_count_ff;
   assign y     = req_data.frame_start ? '0 : row_index_ff;
   assign x_inc = LW'(x) + LW'(1);
   assign y_inc = (ROW_BITS + 1)'(y) + (ROW_BITS + 1)'(1);

   always_comb begin
      column_count_in = x_inc[CW-1:0];
      row_index_in    = y;
      if (x_inc >= w_eff) begin
         column_count_in = '0;
         if (y_inc >= h_eff) begin
            row_index_in = '0;
         end else begin
            row_index_in = y_inc[ROW_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_index_ff    <= '0;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_index_ff    <= row_index_in;
      end
   end

   // candidate test: full neighborhood and centre inside the border
   logic [LW-1:0]       cx;
   logic [ROW_BITS-1:0] cy;
   logic [LW:0]         cx_far;
   logic [ROW_BITS+1:0] cy_far;
   logic                cand;

   assign cx     = LW'(x) - LW'(1);
   assign cy     = y - ROW_BITS'(1);
   assign cx_far = (LW + 1)'(cx) + (LW + 1)'(border_width_ff);
   assign cy_far = (ROW_BITS + 2)'(cy) + (ROW_BITS + 2)'(border_width_ff);
   assign cand   = (x >= CW'(2)) && (y >= ROW_BITS'(2))
                && (cx > LW'(border_width_ff)) && (cx_far < (LW + 1)'(w_eff))
                && (cy > ROW_BITS'(border_width_ff))
                && (cy_far < (ROW_BITS + 2)'(h_eff));

   // line buffers: two row slots per layer, slot y&1 holds row y-2
   resp_type cur [LAYERS];
   resp_type rd_data [LAYERS][2];
   logic     old_slot;

   assign cur[0]   = req_data.lower_response;
   assign cur[1]   = req_data.centre_response;
   assign cur[2]   = req_data.upper_response;
   assign old_slot = y[0];

   for (genvar l = 0; l < LAYERS; l++) begin : g_layer
      for (genvar s = 0; s < 2; s++) begin : g_slot
         sspd_ram #(
            .WIDTH (RESPONSE_BITS),
            .DEPTH (MAX_ROW_LENGTH)
         ) u_row_ram (
            .clock   (clock),
            .wr_en   (accept && (old_slot == 1'(s))),
            .wr_addr (x),
            .wr_data (cur[l]),
            .rd_en   (accept),
            .rd_addr (x),
            .rd_data (rd_data[l][s])
         );
      end
   end

   // stage 1
   resp_type            s1_cur_ff [LAYERS];
   logic                s1_slot_ff;
   logic                s1_cand_ff;
   logic [LW-1:0]       s1_cx_ff;
   logic [ROW_BITS-1:0] s1_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= cur;
         s1_slot_ff <= old_slot;
         s1_cand_ff <= cand;
         s1_cx_ff   <= cx;
         s1_cy_ff   <= cy;
      end
   end

   stack_type col_in;

   always_comb begin
      for (int l = 0; l < LAYERS; l++) begin
         col_in[l][0] = rd_data[l][s1_slot_ff];
         col_in[l][1] = rd_data[l][!s1_slot_ff];
         col_in[l][2] = s1_cur_ff[l];
      end
   end

   // stage 2: window and peak test
   nms_ctrl_type        nms_ctrl;
   resp_type            centre_value;
   logic [LW-1:0]       s2_cx_ff;
   logic [ROW_BITS-1:0] s2_cy_ff;

   assign nms_ctrl.load      = s1_move;
   assign nms_ctrl.threshold = threshold_ff;

   sspd_nms u_nms (
      .clock        (clock),
      .ctrl         (nms_ctrl),
      .col_in       (col_in),
      .is_peak      (is_peak),
      .centre_value (centre_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_cand_ff  <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
         s2_cand_ff  <= s1_cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cx_ff <= s1_cx_ff;
         s2_cy_ff <= s1_cy_ff;
      end
   end

   // result register
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_result;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_result) begin
         rsp_data_ff.peak_x        <= s2_cx_ff[COORD_BITS-1:0];
         rsp_data_ff.peak_y        <= s2_cy_ff;
         rsp_data_ff.peak_strength <= centre_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
